// ----- rtl/sli_pkg.sv -----
// Package for the sorted list intersection unit: payload types, handshake codes and command structs.
`timescale 1ns / 1ps

package sli_pkg;

  localparam int unsigned SERIAL_BITS = 16;
  localparam int unsigned CFG_BITS    = 3;

  localparam logic [CFG_BITS-1:0] NUM_LISTS_RESET = 3'd2;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

  typedef struct packed {
    logic                   req_type;
    logic [1:0]             list_sel;
    logic [SERIAL_BITS-1:0] serial_value;
  } sli_in_t;

  typedef struct packed {
    logic [SERIAL_BITS-1:0] match_serial;
    logic                   none_found;
    logic                   overflow;
    logic                   last;
  } sli_out_t;

  typedef struct packed {
    logic load;
    logic walk_init;
    logic fetch_rst;
    logic fetch;
    logic match;
    logic adv_min;
    logic final_push;
  } sli_cmd_t;

  typedef struct packed {
    logic exhausted;
    logic fetch_last;
    logic all_eq;
    logic pend_valid;
    logic out_space;
  } sli_status_t;

endpackage

// ----- rtl/sli_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module sli_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sli_ctrl.sv -----
// Controller state machine that sequences loads and the intersection walk.
`timescale 1ns / 1ps

module sli_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                req_type_i,
  output logic                in_ready_o,
  input  sli_pkg::sli_status_t status_i,
  output sli_pkg::sli_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CHECK  = 6'b000010,
    ST_FETCH  = 6'b000100,
    ST_WAIT   = 6'b001000,
    ST_DECIDE = 6'b010000,
    ST_FINAL  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == sli_pkg::REQ_RUN) begin
            cmd_o.walk_init = 1'b1;
            state_d         = ST_CHECK;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        if (status_i.exhausted) begin
          state_d = ST_FINAL;
        end else begin
          cmd_o.fetch_rst = 1'b1;
          state_d         = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        if (status_i.fetch_last) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status_i.all_eq) begin
          if (!status_i.pend_valid || status_i.out_space) begin
            cmd_o.match = 1'b1;
            state_d     = ST_CHECK;
          end
        end else begin
          cmd_o.adv_min = 1'b1;
          state_d       = ST_CHECK;
        end
      end
      ST_FINAL: begin
        if (status_i.out_space) begin
          cmd_o.final_push = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

// ----- rtl/sli_datapath.sv -----
// Datapath: list lengths, head pointers, posting store, head comparison and result register.
`timescale 1ns / 1ps

module sli_datapath #(
  parameter int unsigned MAX_LISTS  = 4,
  parameter int unsigned LIST_DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sli_pkg::CFG_BITS-1:0]        cfg_wdata_i,
  input  sli_pkg::sli_in_t                    in_data_i,
  input  sli_pkg::sli_cmd_t                   cmd_i,
  output sli_pkg::sli_status_t                status_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output sli_pkg::sli_out_t                   out_data_o
);

  localparam int unsigned LW = $clog2(MAX_LISTS);
  localparam int unsigned PW = $clog2(LIST_DEPTH);
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned NW = $clog2(MAX_LISTS + 1);
  localparam int unsigned AW = LW + PW;
  localparam int unsigned SB = sli_pkg::SERIAL_BITS;

  logic [sli_pkg::CFG_BITS-1:0] num_lists_q;
  logic [NW-1:0]                n_eff;

  logic [CW-1:0] len_q  [MAX_LISTS];
  logic [CW-1:0] head_q [MAX_LISTS];
  logic          ovf_q;

  logic [LW-1:0] fidx_q;
  logic          rd_valid_q;
  logic [LW-1:0] rd_idx_q;
  logic [SB-1:0] rd_data;

  logic [SB-1:0] first_q;
  logic [SB-1:0] min_q;
  logic [LW-1:0] min_idx_q;
  logic          eq_q;

  logic [SB-1:0] pend_q;
  logic          pend_valid_q;

  logic              out_valid_q;
  sli_pkg::sli_out_t out_q;

  logic          sel_ok;
  logic [LW-1:0] sel_idx;
  logic          sel_full;
  logic          ram_we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic          exhausted;
  logic          out_space;
  logic          push_mid;

  // Out-of-range counts are folded into 1 .. MAX_LISTS.
  always_comb begin
    if (num_lists_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(num_lists_q) > MAX_LISTS) begin
      n_eff = NW'(MAX_LISTS);
    end else begin
      n_eff = NW'(num_lists_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_lists_q <= sli_pkg::NUM_LISTS_RESET;
    end else if (cfg_we_i) begin
      num_lists_q <= cfg_wdata_i;
    end
  end

  assign sel_ok   = (32'(in_data_i.list_sel) < MAX_LISTS);
  assign sel_idx  = LW'(in_data_i.list_sel);
  assign sel_full = (len_q[sel_idx] == CW'(LIST_DEPTH));
  assign ram_we   = cmd_i.load && sel_ok && !sel_full;
  assign waddr    = {sel_idx, len_q[sel_idx][PW-1:0]};
  assign raddr    = {fidx_q, head_q[fidx_q][PW-1:0]};

  sli_ram #(
    .WIDTH (SB),
    .DEPTH (MAX_LISTS * (2 ** PW))
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (in_data_i.serial_value),
    .re_i    (cmd_i.fetch),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  always_comb begin
    exhausted = 1'b0;
    for (int l = 0; l < MAX_LISTS; l++) begin
      if ((32'(l) < 32'(n_eff)) && (head_q[l] >= len_q[l])) begin
        exhausted = 1'b1;
      end
    end
  end

  assign out_space = !out_valid_q || out_ready_i;
  assign push_mid  = cmd_i.match && pend_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < MAX_LISTS; l++) begin
        len_q[l]  <= '0;
        head_q[l] <= '0;
      end
      ovf_q        <= 1'b0;
      fidx_q       <= '0;
      rd_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.load && sel_ok) begin
        if (sel_full) begin
          ovf_q <= 1'b1;
        end else begin
          len_q[sel_idx] <= len_q[sel_idx] + CW'(1);
        end
      end
      if (cmd_i.walk_init) begin
        for (int l = 0; l < MAX_LISTS; l++) begin
          head_q[l] <= '0;
        end
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.fetch_rst) begin
        fidx_q <= '0;
      end else if (cmd_i.fetch) begin
        fidx_q <= fidx_q + LW'(1);
      end
      rd_valid_q <= cmd_i.fetch;
      if (cmd_i.match) begin
        for (int l = 0; l < MAX_LISTS; l++) begin
          if (32'(l) < 32'(n_eff)) begin
            head_q[l] <= head_q[l] + CW'(1);
          end
        end
        pend_valid_q <= 1'b1;
      end
      if (cmd_i.adv_min) begin
        head_q[min_idx_q] <= head_q[min_idx_q] + CW'(1);
      end
      if (cmd_i.final_push) begin
        for (int l = 0; l < MAX_LISTS; l++) begin
          len_q[l] <= '0;
        end
        ovf_q        <= 1'b0;
        pend_valid_q <= 1'b0;
      end
      if (push_mid || cmd_i.final_push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Heads arrive in list order, so the minimum and the equality test build up one per cycle.
  always_ff @(posedge clk_i) begin
    if (rd_valid_q) begin
      if (rd_idx_q == '0) begin
        first_q   <= rd_data;
        min_q     <= rd_data;
        min_idx_q <= '0;
        eq_q      <= 1'b1;
      end else begin
        if (rd_data != first_q) begin
          eq_q <= 1'b0;
        end
        if (rd_data < min_q) begin
          min_q     <= rd_data;
          min_idx_q <= rd_idx_q;
        end
      end
    end
    if (cmd_i.fetch) begin
      rd_idx_q <= fidx_q;
    end
    if (cmd_i.match) begin
      pend_q <= first_q;
    end
    if (push_mid) begin
      out_q.match_serial <= pend_q;
      out_q.none_found   <= 1'b0;
      out_q.overflow     <= ovf_q;
      out_q.last         <= 1'b0;
    end else if (cmd_i.final_push) begin
      out_q.match_serial <= pend_valid_q ? pend_q : '0;
      out_q.none_found   <= !pend_valid_q;
      out_q.overflow     <= ovf_q;
      out_q.last         <= 1'b1;
    end
  end

  assign status_o.exhausted  = exhausted;
  assign status_o.fetch_last = ((32'(fidx_q) + 32'd1) == 32'(n_eff));
  assign status_o.all_eq     = eq_q;
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_space  = out_space;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/sorted_list_intersection_unit.sv -----
// Top level of the sorted list intersection unit: controller and datapath.
`timescale 1ns / 1ps
// A load transaction is accepted while the unit is idle, and loads may follow back to back.
// A run transaction walks the heads in steps of check, fetch, wait and decide, with one head
// read per cycle from the single read port of the posting store; at most the sum of the list
// lengths steps are taken before the report. Results wait in one output register.
// Reset (rst_ni, asynchronous, active low) clears lengths, heads, overflow and the controller
// and sets num_lists to 2; the posting store is not cleared and needs no clearing pass.

module sorted_list_intersection_unit #(
  parameter int unsigned MAX_LISTS  = 4,
  parameter int unsigned LIST_DEPTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sli_pkg::CFG_BITS-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  sli_pkg::sli_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output sli_pkg::sli_out_t            out_data_o
);

  // The controller decides what happens each cycle; the datapath owns all storage but its state.
  // They talk only through the command and status structs below.
  sli_pkg::sli_cmd_t    cmd;
  sli_pkg::sli_status_t status;

  // The controller accepts a transaction only when idle. A load is absorbed in that same
  // cycle, while a run moves the controller into the walk until its final result is queued.
  sli_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (in_data_i.req_type),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Each match is held back by one step, so that the final one can be marked as last once the
  // walk has found that a list is exhausted. An empty intersection gives a single none_found
  // result. The lists and the overflow flag are cleared as the final result is queued.
  sli_datapath #(
    .MAX_LISTS  (MAX_LISTS),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/sli_checker.sv -----
// Port-level checker for the sorted list intersection unit, bound to the top level.
`timescale 1ns / 1ps

module sli_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input sli_pkg::sli_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input sli_pkg::sli_out_t out_data_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // An empty intersection is always the final result of its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.none_found |-> out_data_o.last)
    else $error("none_found result not marked last");

  // An empty intersection carries a zero serial.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.none_found |-> out_data_o.match_serial == '0)
    else $error("none_found result with nonzero serial");

  // Once a run is accepted, the unit is busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.req_type == sli_pkg::REQ_RUN) |=> !in_ready_o)
    else $error("input ready straight after a run transaction");

endmodule

bind sorted_list_intersection_unit sli_checker u_sli_checker (.*);

// ----- verif/tb_sorted_list_intersection_unit.sv -----
// Self-checking testbench for the sorted list intersection unit with a built-in predictor.
`timescale 1ns / 1ps

// The testbench loads posting lists through the input channel, starts runs and compares
// every result transaction with the output of a behavioural predictor. That predictor
// updates its copy of the lists when an input transaction is accepted.
//
// The stimulus has two parts.
//   - A directed part covers the following cases:
//       * an empty run;
//       * the extreme serials 0 and 65535;
//       * ties on the smallest head;
//       * all four lists taking part;
//       * a list count of zero, which behaves as one list;
//       * a list count above the maximum, which saturates;
//       * an unsorted list;
//       * an empty list that takes part in the run.
//   - A random part is built mostly from runs over ascending lists with shared serials.
//     It also holds some noise:
//       * unsorted lists;
//       * runs with no loads at all;
//       * lists that are filled beyond their depth, so that overflow is reported.
//
// The list count register is written only when the unit is idle. That means after reset,
// or once every expected result has arrived and a short settling time has passed. Between
// writes the run moves through every register value, the extremes among them.
//
// Both channels have random back-pressure.
//   - First the sender idles often and the receiver very often.
//   - Then the two rates are swapped.
//   - Finally neither side idles.

module tb_sorted_list_intersection_unit;

  localparam int unsigned MAX_LISTS     = 4;
  localparam int unsigned LIST_DEPTH    = 64;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned RANDOM_ITEMS  = 460;
  localparam int unsigned POOL_SIZE     = 200;
  localparam int unsigned PHASES        = 12;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_we_i    = 1'b0;
  logic [sli_pkg::CFG_BITS-1:0] cfg_wdata_i = '0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  sli_pkg::sli_in_t             in_data_i   = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  sli_pkg::sli_out_t            out_data_o;

  always #5 clk_i = ~clk_i;

  sorted_list_intersection_unit #(
    .MAX_LISTS  (MAX_LISTS),
    .LIST_DEPTH (LIST_DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Predictor state: a copy of the posting lists, their fill levels, the sticky overflow flag
  // and the list count register as the unit should hold them.
  logic [sli_pkg::SERIAL_BITS-1:0] lists_copy [MAX_LISTS][LIST_DEPTH];
  int unsigned                     lens_copy  [MAX_LISTS];
  logic                            overflow_copy  = 1'b0;
  logic [sli_pkg::CFG_BITS-1:0]    num_lists_copy = sli_pkg::NUM_LISTS_RESET;

  // Input transactions still to be sent, and the matches expected from the output channel.
  sli_pkg::sli_in_t  pending_items [$];
  sli_pkg::sli_out_t expected_matches [$];

  int unsigned fail_count    = 0;
  int unsigned random_items  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          in_taken      = 1'b0;

  // Applies one accepted transaction to the predictor. A load appends to its list, or sets
  // overflow when the list is full. A run walks the heads of the lists taking part, queues
  // every match, and then clears the lists.
  task automatic predict_intersection(input sli_pkg::sli_in_t item);
    int unsigned                     n;
    int unsigned                     count;
    int unsigned                     smallest;
    int unsigned                     head [MAX_LISTS];
    logic [sli_pkg::SERIAL_BITS-1:0] first;
    logic [sli_pkg::SERIAL_BITS-1:0] small_val;
    logic [sli_pkg::SERIAL_BITS-1:0] v;
    bit                              done;
    bit                              all_eq;
    sli_pkg::sli_out_t               res;
    if (item.req_type == sli_pkg::REQ_LOAD) begin
      if (lens_copy[item.list_sel] >= LIST_DEPTH) begin
        overflow_copy = 1'b1;
      end else begin
        lists_copy[item.list_sel][lens_copy[item.list_sel]] = item.serial_value;
        lens_copy[item.list_sel]++;
      end
    end else begin
      // A count of zero means one list, and a count above the maximum saturates.
      if (num_lists_copy == 0) begin
        n = 1;
      end else if (num_lists_copy > MAX_LISTS) begin
        n = MAX_LISTS;
      end else begin
        n = 32'(num_lists_copy);
      end
      count = 0;
      for (int l = 0; l < MAX_LISTS; l++) head[l] = 0;
      done = 1'b0;
      while (!done) begin
        for (int l = 0; l < n; l++) begin
          if (head[l] >= lens_copy[l]) done = 1'b1;
        end
        if (!done) begin
          first     = lists_copy[0][head[0]];
          small_val = first;
          smallest  = 0;
          all_eq    = 1'b1;
          // On a tie for the smallest head, the list with the lowest index is advanced.
          for (int l = 1; l < n; l++) begin
            v = lists_copy[l][head[l]];
            if (v != first) all_eq = 1'b0;
            if (v < small_val) begin
              small_val = v;
              smallest  = l;
            end
          end
          if (all_eq) begin
            if (count < LIST_DEPTH) begin
              res.match_serial = first;
              res.none_found   = 1'b0;
              res.overflow     = overflow_copy;
              res.last         = 1'b0;
              expected_matches.insert(expected_matches.size(), res);
              count++;
            end
            for (int l = 0; l < n; l++) head[l]++;
          end else begin
            head[smallest]++;
          end
        end
      end
      if (count == 0) begin
        res.match_serial = '0;
        res.none_found   = 1'b1;
        res.overflow     = overflow_copy;
        res.last         = 1'b1;
        expected_matches.insert(expected_matches.size(), res);
      end else begin
        expected_matches[expected_matches.size() - 1].last = 1'b1;
      end
      for (int l = 0; l < MAX_LISTS; l++) lens_copy[l] = 0;
      overflow_copy = 1'b0;
    end
  endtask

  // Driver, sampling side: a transaction is taken at a rising edge where valid and ready are
  // both high. The predictor sees it at that moment.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_intersection(in_data_i);
      in_taken = 1'b1;
    end
  end

  // Driver, driving side: on the falling edge a new item is offered, but only once the last
  // one was taken. The receiver's ready is also redrawn here. An item that has been offered
  // stays on the bus unchanged until it is accepted.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data_i  <= pending_items[0];
          in_valid_i <= 1'b1;
          pending_items.delete(0);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
    in_taken = 1'b0;
  end

  // Monitor: each result transaction is checked field by field against the oldest expected
  // match.
  always @(posedge clk_i) begin
    sli_pkg::sli_out_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_matches.size() == 0) begin
        $error("unexpected result: match_serial %0d none_found %0d overflow %0d last %0d",
               out_data_o.match_serial, out_data_o.none_found, out_data_o.overflow,
               out_data_o.last);
        fail_count++;
      end else begin
        exp_res = expected_matches[0];
        expected_matches.delete(0);
        if (out_data_o.match_serial !== exp_res.match_serial) begin
          $error("match_serial mismatch: expected %0d actual %0d",
                 exp_res.match_serial, out_data_o.match_serial);
          fail_count++;
        end
        if (out_data_o.none_found !== exp_res.none_found) begin
          $error("none_found mismatch: expected %0d actual %0d",
                 exp_res.none_found, out_data_o.none_found);
          fail_count++;
        end
        if (out_data_o.overflow !== exp_res.overflow) begin
          $error("overflow mismatch: expected %0d actual %0d",
                 exp_res.overflow, out_data_o.overflow);
          fail_count++;
        end
        if (out_data_o.last !== exp_res.last) begin
          $error("last mismatch: expected %0d actual %0d", exp_res.last, out_data_o.last);
          fail_count++;
        end
      end
    end
  end

  task automatic push_load(input int unsigned sel, input int unsigned value);
    sli_pkg::sli_in_t item;
    item.req_type     = sli_pkg::REQ_LOAD;
    item.list_sel     = sel[1:0];
    item.serial_value = value[sli_pkg::SERIAL_BITS-1:0];
    pending_items.insert(pending_items.size(), item);
  endtask

  // The list select and serial fields of a run are don't-care, so they are filled at random.
  task automatic push_run();
    sli_pkg::sli_in_t item;
    int unsigned      rnd_sel;
    int unsigned      rnd_val;
    rnd_sel           = $urandom_range(0, 3);
    rnd_val           = $urandom_range(0, 65535);
    item.req_type     = sli_pkg::REQ_RUN;
    item.list_sel     = rnd_sel[1:0];
    item.serial_value = rnd_val[sli_pkg::SERIAL_BITS-1:0];
    pending_items.insert(pending_items.size(), item);
  endtask

  // Waits until every item has been sent and every expected result has arrived. It then lets
  // the unit settle, since a trailing load gives no result to wait for.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_matches.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_num_lists(input int unsigned value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[sli_pkg::CFG_BITS-1:0];
    @(negedge clk_i);
    cfg_we_i       <= 1'b0;
    num_lists_copy  = value[sli_pkg::CFG_BITS-1:0];
  endtask

  // Builds one random run: the loads for each list, interleaved at random, and then the run
  // itself.
  //   - Most lists are drawn in ascending order from one shared pool, so the intersection is
  //     often not empty.
  //   - Some runs get unsorted lists, and a few get no loads at all.
  //   - A few runs overfill one list.
  task automatic gen_run();
    int unsigned pool [POOL_SIZE];
    int unsigned vals [MAX_LISTS][LIST_DEPTH+4];
    int unsigned want [MAX_LISTS];
    int unsigned have [MAX_LISTS];
    int unsigned pos  [MAX_LISTS];
    int unsigned kind;
    int unsigned v;
    int unsigned pi;
    int unsigned remaining;
    int unsigned l;
    int          ovf_list;
    kind     = $urandom_range(0, 99);
    ovf_list = (kind < 7) ? int'($urandom_range(0, 3)) : -1;
    if (ovf_list >= 0) begin
      v = $urandom_range(0, 30000);
    end else if ($urandom_range(0, 4) == 0) begin
      v = $urandom_range(65535 - 150, 65535);
    end else begin
      v = $urandom_range(0, 65535);
    end
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool[i] = v;
      v = v + (($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3));
      if (v > 65535) v = 65535;
    end
    remaining = 0;
    for (int k = 0; k < MAX_LISTS; k++) begin
      if (k == ovf_list) begin
        want[k] = LIST_DEPTH + $urandom_range(1, 3);
      end else if (kind >= 95) begin
        want[k] = 0;
      end else if ($urandom_range(0, 9) == 0) begin
        want[k] = $urandom_range(7, 24);
      end else begin
        want[k] = $urandom_range(0, 6);
      end
      have[k] = 0;
      pos[k]  = 0;
      if (kind >= 7 && kind < 15) begin
        while (have[k] < want[k]) begin
          vals[k][have[k]] = $urandom_range(0, 65535);
          have[k]++;
        end
      end else begin
        pi = 0;
        while (have[k] < want[k] && pi < POOL_SIZE) begin
          if (k == ovf_list || $urandom_range(0, 99) < 75) begin
            vals[k][have[k]] = pool[pi];
            have[k]++;
          end
          pi++;
        end
      end
      remaining += have[k];
    end
    random_items += remaining + 1;
    while (remaining > 0) begin
      l = $urandom_range(0, MAX_LISTS - 1);
      if (pos[l] < have[l]) begin
        push_load(l, vals[l][pos[l]]);
        pos[l]++;
        remaining--;
      end
    end
    push_run();
  endtask

  // Register values for the random phases. Every value is used, 0 and 7 among them.
  int unsigned cfg_plan [PHASES] = '{1, 4, 2, 3, 7, 0, 5, 1, 3, 4, 6, 7};

  initial begin
    for (int l = 0; l < MAX_LISTS; l++) lens_copy[l] = 0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 29;
    recv_idle_pct = 84;

    // Directed part, with the reset list count of two. First a run over empty lists, then
    // the extreme serials in both lists.
    push_run();
    push_load(0, 0);
    push_load(0, 5);
    push_load(0, 65535);
    push_load(1, 0);
    push_load(1, 7);
    push_load(1, 65535);
    push_run();
    wait_drained();

    // With all four lists taking part, the smallest head is at one point tied between the
    // first two lists, and the list with the lower index advances.
    write_num_lists(MAX_LISTS);
    push_load(0, 2);
    push_load(0, 3);
    push_load(0, 9);
    push_load(1, 2);
    push_load(1, 3);
    push_load(1, 9);
    push_load(2, 1);
    push_load(2, 3);
    push_load(2, 9);
    push_load(3, 3);
    push_load(3, 4);
    push_load(3, 9);
    push_run();
    wait_drained();

    // A count of zero acts as one list, so an unsorted list comes out as loaded.
    write_num_lists(0);
    push_load(0, 16'h5555);
    push_load(0, 16'h1234);
    push_load(1, 16'hAAAA);
    push_run();
    wait_drained();

    // A count above the maximum saturates, and the empty fourth list gives no match.
    write_num_lists(7);
    push_load(0, 42);
    push_load(1, 42);
    push_load(2, 42);
    push_run();
    wait_drained();

    // Random part: three idling regimes, each spread over four register settings.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct = 84;
        end
        1: begin
          send_idle_pct = 84;
          recv_idle_pct = 29;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int p = 0; p < 4; p++) begin
        write_num_lists(cfg_plan[mode * 4 + p]);
        while (random_items < RANDOM_ITEMS * (mode * 4 + p + 1) / PHASES) gen_run();
        wait_drained();
      end
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run under the heaviest back-pressure.
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
